// File: hdl/bsnl_pkg.sv
// Shared types and constants for the bounded sorted neighbor list.
package bsnl_pkg;

   // Field widths of a request and a response transaction.
   localparam int INDEX_W = 16;
   localparam int KEY_W   = 32;
   localparam int RANK_W  = 5;
   localparam int CAP_W   = 6;
   localparam int COUNT_W = 6;

   // Default list depth and the capacity after reset.
   localparam int             DEPTH_DEFAULT = 32;
   localparam logic [CAP_W-1:0] CAP_RESET   = 6'd32;

   // Request operation codes.
   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_READ   = 2'd1,
      MODE_CLEAR  = 2'd2,
      MODE_NOP    = 2'd3
   } mode_type;

   // One stored neighbor: identifier and squared-distance key.
   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic [KEY_W-1:0]   key;
   } entry_type;

   // Insert command broadcast to every cell of the chain.
   typedef struct packed {
      logic      shift_en;
      entry_type entry;
   } ins_cmd_type;

   // Registered response payload.
   typedef struct packed {
      logic [INDEX_W-1:0] out_index;
      logic [KEY_W-1:0]   out_key;
      logic               out_valid;
      logic               accepted;
      logic [COUNT_W-1:0] count;
   } result_type;

endpackage

// File: hdl/bsnl_if.sv
// Valid/ready channel interfaces for requests and responses.
interface bsnl_req_if;
   import bsnl_pkg::*;

   logic               valid;
   logic               ready;
   logic [1:0]         mode;
   logic [INDEX_W-1:0] entry_index;
   logic [KEY_W-1:0]   entry_key;
   logic [RANK_W-1:0]  read_rank;

   modport source (output valid, mode, entry_index, entry_key, read_rank, input ready);
   modport sink   (input valid, mode, entry_index, entry_key, read_rank, output ready);
endinterface

interface bsnl_rsp_if;
   import bsnl_pkg::*;

   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] out_index;
   logic [KEY_W-1:0]   out_key;
   logic               out_valid;
   logic               accepted;
   logic [COUNT_W-1:0] count;

   modport source (output valid, out_index, out_key, out_valid, accepted, count,
                   input ready);
   modport sink   (input valid, out_index, out_key, out_valid, accepted, count,
                   output ready);
endinterface

// File: hdl/bsnl_cell.sv
// One cell of the sorted chain: holds one entry and shifts toward higher ranks.
module bsnl_cell (
   input  logic                   clock,
   input  bsnl_pkg::ins_cmd_type  cmd,
   input  logic                   cell_valid,
   input  logic                   left_less,
   input  bsnl_pkg::entry_type    left_entry,
   output bsnl_pkg::entry_type    entry,
   output logic                   less
);
   import bsnl_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // The held key sorts strictly before the offered key.
   assign less  = cell_valid && (entry_ff.key < cmd.entry.key);
   assign entry = entry_ff;

   // Keep when smaller, take the new entry at the boundary, else take the left neighbor.
   always_comb begin
      entry_in = entry_ff;
      if (cmd.shift_en && !less) begin
         if (left_less) begin
            entry_in = cmd.entry;
         end else begin
            entry_in = left_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// File: hdl/bounded_sorted_neighbor_list_unit.sv
// A taken transaction's result is registered in the output register, unless a capacity write comes in the same cycle.
// Throughput: one transaction per cycle while req.ready is high; every cell compares and shifts together.
// The request side stalls only while a finished result waits and the response side is stalled.
// Reset clears the count and the response valid and sets capacity to 32; cell contents
// stay undefined and are never read before they are written.
module bounded_sorted_neighbor_list_unit #(
   parameter int DEPTH = bsnl_pkg::DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [bsnl_pkg::CAP_W-1:0] csr_wr_data,
   bsnl_req_if.sink                   req,
   bsnl_rsp_if.source                 rsp
);
   import bsnl_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CAP_W-1:0] capacity_ff, capacity_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       result_ff, result_in;

   ins_cmd_type      cmd;
   entry_type        cell_entry [DEPTH];
   logic [DEPTH-1:0] cell_valid;
   logic [DEPTH-1:0] cell_less;
   logic [CNT_W-1:0] eff_cap;
   logic [CNT_W-1:0] new_eff_cap;
   logic             fire;
   logic             full;
   logic             accepted;
   logic [KEY_W-1:0] last_key;
   entry_type        read_entry;
   logic             read_ok;

   // Clamp a raw capacity value into the range one to DEPTH.
   function automatic logic [CNT_W-1:0] clamp_cap(input logic [CAP_W-1:0] raw);
      logic [CNT_W-1:0] c;
      if (raw == '0) begin
         c = CNT_W'(1);
      end else if (int'(raw) > DEPTH) begin
         c = CNT_W'(DEPTH);
      end else begin
         c = CNT_W'(raw);
      end
      return c;
   endfunction

   assign eff_cap     = clamp_cap(capacity_ff);
   assign new_eff_cap = clamp_cap(csr_wr_data);

   // Handshake: the output register frees up when its result is taken.
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign fire      = req.valid && req.ready;

   // Insert command broadcast along the chain; a dropped insert moves nothing.
   assign cmd.shift_en    = fire && (mode_type'(req.mode) == MODE_INSERT) && accepted;
   assign cmd.entry.index = req.entry_index;
   assign cmd.entry.key   = req.entry_key;

   // Chain of cells; cell zero sees an always-smaller left neighbor.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign cell_valid[i] = count_ff > CNT_W'(i);
      if (i == 0) begin : g_head
         bsnl_cell u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .cell_valid (cell_valid[i]),
            .left_less  (1'b1),
            .left_entry (cmd.entry),
            .entry      (cell_entry[i]),
            .less       (cell_less[i])
         );
      end else begin : g_body
         bsnl_cell u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .cell_valid (cell_valid[i]),
            .left_less  (cell_less[i-1]),
            .left_entry (cell_entry[i-1]),
            .entry      (cell_entry[i]),
            .less       (cell_less[i])
         );
      end
   end

   // Largest held key, found in the last valid cell of the chain.
   always_comb begin
      last_key = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (count_ff == CNT_W'(i + 1)) begin
            last_key = cell_entry[i].key;
         end
      end
   end

   // A full list drops the key unless it is below the largest held key.
   assign full     = count_ff >= eff_cap;
   assign accepted = !full || (req.entry_key < last_key);

   // Read selection over the cells by rank.
   always_comb begin
      read_entry = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (int'(req.read_rank) == i) begin
            read_entry = cell_entry[i];
         end
      end
   end
   assign read_ok = CNT_W'(req.read_rank) < count_ff && int'(req.read_rank) < DEPTH;

   // Next count, capacity and result for the current transaction.
   always_comb begin
      capacity_in  = capacity_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      result_in    = result_ff;
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_wr_en) begin
         capacity_in = csr_wr_data;
         if (count_ff > new_eff_cap) begin
            count_in = new_eff_cap;
         end
      end else if (fire) begin
         rsp_valid_in = 1'b1;
         result_in    = '0;
         case (mode_type'(req.mode))
            MODE_INSERT: begin
               result_in.accepted = accepted;
               if (accepted && !full) begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
            MODE_READ: begin
               if (read_ok) begin
                  result_in.out_index = read_entry.index;
                  result_in.out_key   = read_entry.key;
                  result_in.out_valid = 1'b1;
               end
            end
            MODE_CLEAR: begin
               count_in = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
         result_in.count = COUNT_W'(count_in);
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAP_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.out_index = result_ff.out_index;
   assign rsp.out_key   = result_ff.out_key;
   assign rsp.out_valid = result_ff.out_valid;
   assign rsp.accepted  = result_ff.accepted;
   assign rsp.count     = result_ff.count;

endmodule
